@@ hw/rtl/lru_pkg.sv @@
// shared types and constants for the lru key-value cache
`default_nettype none
package lru_pkg;

	localparam int LRU_ENTRIES    = 16;
	localparam int LRU_KEY_WIDTH  = 32;
	localparam int LRU_DATA_WIDTH = 32;

	localparam int          CAP_W     = 5;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	typedef enum logic {
		OP_LOOKUP = 1'b0,
		OP_INSERT = 1'b1
	} op_t;

	typedef struct packed {
		op_t                op;
		logic        [31:0] key;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic               hit;
		logic signed [31:0] found_value;
	} rsp_t;

endpackage
`default_nettype wire

@@ hw/rtl/lru_cache.sv @@
// lru key-value cache top level: fully associative store with lru replacement
`default_nettype none

// Fully associative key-value cache with least-recently-used replacement.
// An item is taken at a rising edge with start high; busy is always low, so a
// new item may be issued every cycle and each sees the state left by the one
// before it. An item is registered, then matched against every entry in
// parallel and the entry table, recency ranks and occupancy are updated in the
// next cycle; a lookup gives its result on rsp, from the result register, with done
// high for exactly one cycle, and the receiver cannot stall it.
// Inserts give no result. The capacity register (cfg_we, cfg_wdata) may only
// be written while no item is in flight; zero acts as one and values above the
// entry count act as the entry count. Lowering it evicts nothing at once.
module lru_cache
	import lru_pkg::*;
#(
	parameter int ENTRIES    = LRU_ENTRIES,
	parameter int KEY_WIDTH  = LRU_KEY_WIDTH,
	parameter int DATA_WIDTH = LRU_DATA_WIDTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output      logic             busy,
	input  wire req_t             req,
	output      logic             done,
	output      rsp_t             rsp,
	input  wire logic             cfg_we,
	input  wire logic [CAP_W-1:0] cfg_wdata
);

	localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W  = $clog2(ENTRIES + 1);
	localparam int CW     = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	logic [CAP_W-1:0] cap_q;

	logic vld_s1;
	req_t req_s1;

	logic [ENTRIES-1:0]    valid_q;
	logic [RANK_W-1:0]     rank_q [ENTRIES];
	logic [KEY_WIDTH-1:0]  key_q  [ENTRIES];
	logic [DATA_WIDTH-1:0] data_q [ENTRIES];
	logic [CNT_W-1:0]      occ_q;

	logic done_q;
	rsp_t rsp_q;

	logic [KEY_WIDTH-1:0]  key_in;
	logic [DATA_WIDTH-1:0] val_in;
	logic [ENTRIES-1:0]    match;
	logic                  hit;
	logic [RANK_W-1:0]     hit_rank;
	logic [DATA_WIDTH-1:0] hit_data;
	logic [CW-1:0]         cap_ext;
	logic [CW-1:0]         eff_cap;
	logic                  full;
	logic [RANK_W-1:0]     oldest_rank;
	logic [ENTRIES-1:0]    victim;
	logic                  is_ins;
	logic                  do_evict;
	logic                  do_new;
	logic                  do_touch;
	logic                  do_upd;
	logic [ENTRIES-1:0]    valid_ev;
	logic [ENTRIES-1:0]    free;
	logic [ENTRIES-1:0]    slot;
	logic [ENTRIES-1:0]    valid_d;
	logic [RANK_W-1:0]     rank_d [ENTRIES];
	logic [CNT_W-1:0]      occ_d;

	assign busy = 1'b0;

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_s1 <= req;
		end
	end

	// match, victim and free slot
	always_comb begin
		key_in   = KEY_WIDTH'(req_s1.key);
		val_in   = DATA_WIDTH'($unsigned(req_s1.value));
		hit_rank = '0;
		hit_data = '0;
		oldest_rank = RANK_W'(occ_q - CNT_W'(1));
		for (int i = 0; i < ENTRIES; i++) begin
			match[i]  = valid_q[i] && (key_q[i] == key_in);
			victim[i] = valid_q[i] && (rank_q[i] == oldest_rank);
			hit_rank  = hit_rank | (rank_q[i] & {RANK_W{match[i]}});
			hit_data  = hit_data | (data_q[i] & {DATA_WIDTH{match[i]}});
		end
		hit = |match;

		cap_ext = CW'(cap_q);
		if (cap_ext == '0) begin
			eff_cap = CW'(1);
		end else if (cap_ext > CW'(ENTRIES)) begin
			eff_cap = CW'(ENTRIES);
		end else begin
			eff_cap = cap_ext;
		end
		full = CW'(occ_q) >= eff_cap;

		is_ins   = (req_s1.op == OP_INSERT);
		do_touch = vld_s1 && hit;
		do_upd   = vld_s1 && is_ins && hit;
		do_evict = vld_s1 && is_ins && !hit && full;
		valid_ev = do_evict ? (valid_q & ~victim) : valid_q;
		free     = ~valid_ev;
		slot     = free & (~free + ENTRIES'(1));
		do_new   = vld_s1 && is_ins && !hit && (|free);
	end

	// next valid bits, ranks and occupancy
	always_comb begin
		valid_d = valid_ev | (do_new ? slot : '0);
		occ_d   = occ_q - CNT_W'(do_evict) + CNT_W'(do_new);
		for (int i = 0; i < ENTRIES; i++) begin
			rank_d[i] = rank_q[i];
			if (do_touch) begin
				if (match[i]) begin
					rank_d[i] = '0;
				end else if (valid_q[i] && (rank_q[i] < hit_rank)) begin
					rank_d[i] = rank_q[i] + RANK_W'(1);
				end
			end else if (do_new) begin
				if (slot[i] || !valid_ev[i]) begin
					rank_d[i] = '0;
				end else begin
					rank_d[i] = rank_q[i] + RANK_W'(1);
				end
			end else if (do_evict && victim[i]) begin
				rank_d[i] = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			occ_q   <= '0;
			for (int i = 0; i < ENTRIES; i++) begin
				rank_q[i] <= '0;
			end
		end else begin
			valid_q <= valid_d;
			occ_q   <= occ_d;
			for (int i = 0; i < ENTRIES; i++) begin
				rank_q[i] <= rank_d[i];
			end
		end
	end

	// entry table
	always_ff @(posedge clk) begin
		for (int i = 0; i < ENTRIES; i++) begin
			if (do_new && slot[i]) begin
				key_q[i]  <= key_in;
				data_q[i] <= val_in;
			end else if (do_upd && match[i]) begin
				data_q[i] <= val_in;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_s1 && (req_s1.op == OP_LOOKUP);
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1 && (req_s1.op == OP_LOOKUP)) begin
			rsp_q.hit         <= hit;
			rsp_q.found_value <= $signed(32'(hit_data));
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

`ifndef SYNTHESIS
	a_occ_count : assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == int'(occ_q))
		else $error("occupancy does not match valid entries");

	a_occ_bound : assert property (@(posedge clk) disable iff (!arst_n)
		int'(occ_q) <= ENTRIES)
		else $error("occupancy above entry count");

	a_done_src : assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(vld_s1 && (req_s1.op == OP_LOOKUP)))
		else $error("result without a lookup");

	a_one_match : assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> $onehot0(match))
		else $error("key stored in more than one entry");
`endif

endmodule
`default_nettype wire

@@ tb/tb_lru_cache.sv @@
// self-checking testbench for the lru key-value cache
`default_nettype none
module tb_lru_cache;
	import lru_pkg::*;

	localparam int NSLOTS      = LRU_ENTRIES;
	localparam int QUIET_LIMIT = 2000;
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 237;
	localparam int POOL_MAX    = 48;

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	req_t             req;
	logic             done;
	rsp_t             rsp;
	logic             cfg_we;
	logic [CAP_W-1:0] cfg_wdata;

	lru_cache i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.done      (done),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// model of the cache contents
	bit                 slot_valid [NSLOTS];
	logic        [31:0] slot_key   [NSLOTS];
	logic signed [31:0] slot_data  [NSLOTS];
	logic        [3:0]  slot_age   [NSLOTS];
	logic        [4:0]  occupancy;
	logic [CAP_W-1:0]   capacity;

	rsp_t lookup_results [$];
	int   errors;
	int   quiet_cycles;
	int   idle_pct;

	logic [31:0] key_pool [POOL_MAX];
	int          pool_size;

	typedef struct {
		bit               is_cfg;
		logic [CAP_W-1:0] cap;
		req_t             item;
		bit               fixed;
		rsp_t             want;
	} plan_row_t;

	plan_row_t plan [$];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		errors++;
	endtask

	// most recent gets age zero, younger entries age by one
	task automatic promote(input int s);
		logic [3:0] a;
		a = slot_age[s];
		for (int i = 0; i < NSLOTS; i++) begin
			if (slot_valid[i] && slot_age[i] < a)
				slot_age[i]++;
		end
		slot_age[s] = '0;
	endtask

	task automatic cache_access(input req_t r, output rsp_t res, output bit gives);
		int         s;
		int         victim;
		int         free_slot;
		int         eff;
		logic [3:0] worst;
		s = -1;
		for (int i = 0; i < NSLOTS; i++) begin
			if (s < 0 && slot_valid[i] && slot_key[i] == r.key)
				s = i;
		end
		res   = '0;
		gives = (r.op == OP_LOOKUP);
		if (r.op == OP_LOOKUP) begin
			if (s >= 0) begin
				res.hit         = 1'b1;
				res.found_value = slot_data[s];
				promote(s);
			end
		end else if (s >= 0) begin
			slot_data[s] = r.value;
			promote(s);
		end else begin
			eff = (capacity == 0) ? 1 : (capacity > NSLOTS) ? NSLOTS : int'(capacity);
			if (int'(occupancy) >= eff) begin
				victim = -1;
				worst  = '0;
				for (int i = 0; i < NSLOTS; i++) begin
					if (slot_valid[i] && (victim < 0 || slot_age[i] > worst)) begin
						victim = i;
						worst  = slot_age[i];
					end
				end
				if (victim >= 0) begin
					slot_valid[victim] = 1'b0;
					slot_age[victim]   = '0;
					occupancy--;
				end
			end
			free_slot = -1;
			for (int i = 0; i < NSLOTS; i++) begin
				if (free_slot < 0 && !slot_valid[i])
					free_slot = i;
			end
			if (free_slot >= 0) begin
				for (int i = 0; i < NSLOTS; i++) begin
					if (slot_valid[i])
						slot_age[i]++;
				end
				slot_valid[free_slot] = 1'b1;
				slot_key[free_slot]   = r.key;
				slot_data[free_slot]  = r.value;
				slot_age[free_slot]   = '0;
				occupancy++;
			end
		end
	endtask

	task automatic issue(input req_t r, input bit fixed, input rsp_t fixed_rsp);
		rsp_t res;
		bit   gives;
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		req   <= r;
		do @(posedge clk); while (busy);
		cache_access(r, res, gives);
		if (gives)
			lookup_results.push_back(fixed ? fixed_rsp : res);
	endtask

	task automatic drain_results();
		start <= 1'b0;
		do @(posedge clk); while (lookup_results.size() != 0);
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] v);
		drain_results();
		// inserts give no result, so let the pipeline empty
		repeat (4) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		capacity   = v;
	endtask

	function automatic req_t random_req();
		req_t r;
		r.op    = op_t'($urandom_range(1));
		r.key   = ($urandom_range(15) == 0) ? $urandom : key_pool[$urandom_range(pool_size - 1)];
		r.value = $urandom;
		return r;
	endfunction

	task automatic add_item(input op_t op, input logic [31:0] k, input logic [31:0] v,
			input bit fixed = 1'b0, input logic h = 1'b0, input logic [31:0] fv = '0);
		plan_row_t row;
		row.is_cfg           = 1'b0;
		row.cap              = '0;
		row.item.op          = op;
		row.item.key         = k;
		row.item.value       = v;
		row.fixed            = fixed;
		row.want.hit         = h;
		row.want.found_value = fv;
		plan.push_back(row);
	endtask

	task automatic add_cfg(input logic [CAP_W-1:0] cap);
		plan_row_t row;
		row        = '{default: '0};
		row.is_cfg = 1'b1;
		row.cap    = cap;
		plan.push_back(row);
	endtask

	always @(posedge clk) begin : result_check
		rsp_t want;
		if (arst_n) begin
			if (done) begin
				if (lookup_results.size() == 0) begin
					report("result with no lookup outstanding");
				end else begin
					want = lookup_results.pop_front();
					if (rsp.hit !== want.hit)
						report($sformatf("hit %b, expected %b", rsp.hit, want.hit));
					if (rsp.found_value !== want.found_value)
						report($sformatf("found_value %h, expected %h",
							rsp.found_value, want.found_value));
				end
			end
			if ((start && !busy) || done || cfg_we)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("watchdog: no progress for %0d cycles", QUIET_LIMIT);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin
		logic [CAP_W-1:0] cap;
		arst_n       = 1'b0;
		start        = 1'b0;
		req          = '0;
		cfg_we       = 1'b0;
		cfg_wdata    = '0;
		errors       = 0;
		quiet_cycles = 0;
		idle_pct     = 0;
		pool_size    = 1;
		capacity     = CAP_RESET;
		occupancy    = '0;
		for (int i = 0; i < NSLOTS; i++) begin
			slot_valid[i] = 1'b0;
			slot_key[i]   = '0;
			slot_data[i]  = '0;
			slot_age[i]   = '0;
		end

		// directed part
		add_item(OP_LOOKUP, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000);
		add_item(OP_INSERT, 32'h0000_0000, 32'h7fff_ffff);
		add_item(OP_INSERT, 32'hffff_ffff, 32'h8000_0000);
		add_item(OP_LOOKUP, 32'hffff_ffff, 32'h7fff_ffff, 1'b1, 1'b1, 32'h8000_0000);
		add_item(OP_LOOKUP, 32'h0000_0000, 32'hffff_ffff, 1'b1, 1'b1, 32'h7fff_ffff);
		add_item(OP_INSERT, 32'h0000_0000, 32'h0000_0000);
		add_item(OP_LOOKUP, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000);
		add_item(OP_LOOKUP, 32'h8000_0000, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000);
		// zero acts as one, above it each new key replaces the oldest entry
		add_cfg(5'd0);
		add_item(OP_INSERT, 32'h0000_0005, 32'h0000_0037);
		add_item(OP_LOOKUP, 32'hffff_ffff, 32'h0000_0000);
		add_item(OP_LOOKUP, 32'h0000_0000, 32'h0000_0000);
		add_item(OP_INSERT, 32'h0000_0006, 32'hffff_fffa);
		add_item(OP_LOOKUP, 32'h0000_0005, 32'h0000_0000);
		add_item(OP_LOOKUP, 32'h0000_0006, 32'h0000_0000);
		// above the entry count acts as the entry count
		add_cfg(5'd31);
		add_item(OP_INSERT, 32'h0000_0007, 32'h1234_5678);
		add_item(OP_INSERT, 32'h0000_0008, 32'h8765_4321);
		add_item(OP_LOOKUP, 32'h0000_0007, 32'h0000_0000);
		add_item(OP_LOOKUP, 32'h0000_0000, 32'h0000_0000);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].is_cfg)
				write_capacity(plan[i].cap);
			else
				issue(plan[i].item, plan[i].fixed, plan[i].want);
		end

		// random part
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0:       cap = 5'd16;
				1:       cap = 5'd1;
				2:       cap = 5'd0;
				3:       cap = 5'd31;
				4:       cap = 5'd2;
				default: cap = CAP_W'($urandom_range(31));
			endcase
			write_capacity(cap);
			case (ph % 3)
				0:       idle_pct = 0;
				1:       idle_pct = 87;
				default: idle_pct = 27;
			endcase
			pool_size = $urandom_range(4, 40);
			for (int i = 0; i < POOL_MAX; i++)
				key_pool[i] = $urandom;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(63) == 0)
					drain_results();
				issue(random_req(), 1'b0, '0);
			end
		end

		drain_results();
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
`default_nettype wire
